// ===== rtl/core/plk_pkg.sv =====
// Shared types, widths and the key table for the piano key lookup.
package plk_pkg;

  // Fixed field widths
  localparam int unsigned FREQ_W     = 24;
  localparam int unsigned KEY_W      = 7;
  localparam int unsigned TABLE_KEYS = 88;
  localparam int unsigned DHZ_W      = 26;

  // Table is held in units of 1/10000 Hz; rounding to fixed point is half up
  localparam int unsigned KEY_DIV   = 10000;
  localparam int unsigned KEY_ROUND = 5000;

  typedef logic [FREQ_W-1:0] freq_t;
  typedef logic [KEY_W-1:0]  key_t;

  // Equal-tempered key frequencies, A0 to C8, strictly increasing
  localparam logic [DHZ_W-1:0] KEY_DHZ [TABLE_KEYS] = '{
    26'd275000,   26'd291352,   26'd308677,   26'd327032,
    26'd346478,   26'd367081,   26'd388909,   26'd412034,
    26'd436535,   26'd462493,   26'd489994,   26'd519131,
    26'd550000,   26'd582705,   26'd617354,   26'd654064,
    26'd692957,   26'd734162,   26'd777817,   26'd824069,
    26'd873071,   26'd924986,   26'd979989,   26'd1038260,
    26'd1100000,  26'd1165410,  26'd1234710,  26'd1308130,
    26'd1385910,  26'd1468320,  26'd1555630,  26'd1648140,
    26'd1746140,  26'd1849970,  26'd1959980,  26'd2076520,
    26'd2200000,  26'd2330820,  26'd2469420,  26'd2616260,
    26'd2771830,  26'd2936650,  26'd3111270,  26'd3296280,
    26'd3492280,  26'd3699940,  26'd3919950,  26'd4153050,
    26'd4400000,  26'd4661640,  26'd4938830,  26'd5232510,
    26'd5543650,  26'd5873300,  26'd6222540,  26'd6592550,
    26'd6984560,  26'd7399890,  26'd7839910,  26'd8306090,
    26'd8800000,  26'd9323280,  26'd9877670,  26'd10465000,
    26'd11087300, 26'd11746600, 26'd12445100, 26'd13185100,
    26'd13969100, 26'd14799800, 26'd15679800, 26'd16612200,
    26'd17600000, 26'd18646600, 26'd19755300, 26'd20930000,
    26'd22174600, 26'd23493200, 26'd24890200, 26'd26370200,
    26'd27938300, 26'd29599600, 26'd31359600, 26'd33224400,
    26'd35200000, 26'd37293100, 26'd39510700, 26'd41860100
  };

  // Key frequency in fixed point, evaluated at elaboration only
  function automatic logic [63:0] key_fixed(input key_t k, input int unsigned frac);
    logic [63:0] v;
    v = 64'(KEY_DHZ[k]);
    return ((v << frac) + 64'(KEY_ROUND)) / 64'(KEY_DIV);
  endfunction

  // Sum of keys k-1 and k: twice the midpoint between them
  function automatic logic [63:0] pair_fixed(input key_t k, input int unsigned frac);
    return key_fixed(k - key_t'(1), frac) + key_fixed(k, frac);
  endfunction

endpackage

// ===== rtl/core/nearest_piano_key_lookup.sv =====
// Nearest piano key lookup. Each beat on the input carries a frequency in
// unsigned fixed point with FRAC_BITS fraction bits; the block returns the
// index of the nearest key of an equal-tempered piano (0 is A0, 87 is C8),
// with frequencies at or below A0 giving 0, at or above the top key giving
// the last index, and an exact midpoint going to the higher key. One beat
// is accepted every cycle unless the input stalls: the beat sits in the input
// register, then the parallel comparator bank and thermometer encoder feed
// the result register, which loads when empty or when its result is taken.
// When the output stalls, the input register still takes a beat while it is
// empty, and stalls only when both registers are full.
// NUM_KEYS above 88 uses the 88 keys of the table.
module nearest_piano_key_lookup #(
  parameter int unsigned NUM_KEYS  = 88,
  parameter int unsigned FRAC_BITS = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  plk_pkg::freq_t frequency,
  output logic           out_valid,
  input  logic           out_stall,
  output plk_pkg::key_t  key_index
);

  localparam int unsigned USED_KEYS =
    (NUM_KEYS < plk_pkg::TABLE_KEYS) ? NUM_KEYS : plk_pkg::TABLE_KEYS;
  localparam int unsigned NUM_PAIRS = USED_KEYS - 1;

  logic                 hold_valid;
  plk_pkg::freq_t       hold_freq;
  logic                 out_load;
  logic [NUM_PAIRS-1:0] above;
  plk_pkg::key_t        index_next;

  // Result register loads when empty or when its beat is being taken
  assign out_load = ~out_valid | ~out_stall;
  assign in_stall = hold_valid & ~out_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (~in_stall) begin
      hold_valid <= in_valid;
    end
    if (~in_stall && in_valid) begin
      hold_freq <= frequency;
    end
  end

  plk_compare #(
    .NUM_PAIRS (NUM_PAIRS),
    .FRAC_BITS (FRAC_BITS)
  ) u_compare (
    .frequency (hold_freq),
    .above     (above)
  );

  plk_encode #(
    .NUM_PAIRS (NUM_PAIRS)
  ) u_encode (
    .above     (above),
    .key_index (index_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= hold_valid;
    end
    if (out_load && hold_valid) begin
      key_index <= index_next;
    end
  end

  // The input side only stalls with a beat held
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_valid)
    else $error("input stalled with empty input register");

  // A held beat reaching a free result register shows up next cycle
  a_moves_on: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && out_load) |=> out_valid)
    else $error("held beat lost on the way to the result register");

  // The index never runs past the last key in use
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (key_index <= plk_pkg::KEY_W'(NUM_PAIRS)))
    else $error("key index beyond last key");

endmodule

// ===== rtl/core/plk_compare.sv =====
// Bank of constant comparators: one per adjacent key pair.
// Bit j is set when 2*frequency is at or above key j plus key j+1.
// The table is increasing, so the result is a thermometer code.
module plk_compare #(
  parameter int unsigned NUM_PAIRS = 87,
  parameter int unsigned FRAC_BITS = 10
) (
  input  plk_pkg::freq_t        frequency,
  output logic [NUM_PAIRS-1:0]  above
);

  localparam int unsigned PAIR_W = plk_pkg::DHZ_W + FRAC_BITS + 1;

  logic [PAIR_W-1:0] twice;

  // 2*frequency, zero extended to the pair width
  assign twice = {{(PAIR_W - plk_pkg::FREQ_W - 1){1'b0}}, frequency, 1'b0};

  for (genvar j = 0; j < NUM_PAIRS; j++) begin : g_pair
    localparam logic [PAIR_W-1:0] PAIR =
      PAIR_W'(plk_pkg::pair_fixed(plk_pkg::KEY_W'(j + 1), FRAC_BITS));
    assign above[j] = (twice >= PAIR);
  end

endmodule

// ===== rtl/core/plk_encode.sv =====
// Thermometer to binary: the index is the count of set bits, found as
// the position of the single 1-to-0 step.
module plk_encode #(
  parameter int unsigned NUM_PAIRS = 87
) (
  input  logic [NUM_PAIRS-1:0] above,
  output plk_pkg::key_t        key_index
);

  logic [NUM_PAIRS:0] step;

  // step[j]: exactly j pairs lie at or below 2*frequency
  for (genvar j = 0; j <= NUM_PAIRS; j++) begin : g_step
    if (j == 0) begin : g_lo
      assign step[j] = ~above[0];
    end else if (j == NUM_PAIRS) begin : g_hi
      assign step[j] = above[j-1];
    end else begin : g_mid
      assign step[j] = above[j-1] & ~above[j];
    end
  end

  // OR together the index of the one step that is set
  always_comb begin
    key_index = '0;
    for (int unsigned j = 0; j <= NUM_PAIRS; j++) begin
      if (step[j]) begin
        key_index = key_index | plk_pkg::KEY_W'(j);
      end
    end
  end

endmodule
